// ----- design/nsdr_pkg.sv -----
// ----------------------------------------------------------------------------
// nsdr_pkg
// Shared types and constants of the n-step discounted return builder.
// ----------------------------------------------------------------------------
package nsdr_pkg;

    localparam int MAX_WINDOW_DEF = 8;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAMMA         = 1'b0,
        CFG_WINDOW_LENGTH = 1'b1
    } cfg_index_t;

    localparam logic [15:0] GAMMA_RESET         = 16'd32440;
    localparam logic [3:0]  WINDOW_LENGTH_RESET = 4'd8;
    localparam logic [15:0] GAMMA_ONE           = 16'd32768;

    // Q1.15 rounding
    localparam int ROUND_HALF = 16384;
    localparam int FRAC_SHIFT = 15;

    typedef struct packed {
        logic [15:0]        cur_state_id;
        logic [7:0]         act;
        logic signed [31:0] reward;
        logic [15:0]        next_state_id;
        logic signed [31:0] next_value;
        logic               episode_done;
    } item_t;

endpackage

// ----- design/nsdr_in_if.sv -----
// ----------------------------------------------------------------------------
// nsdr_in_if
// Transition channel: valid/ready handshake with one transition as payload.
// ----------------------------------------------------------------------------
interface nsdr_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        cur_state_id;
    logic [7:0]         act;
    logic signed [31:0] reward;
    logic [15:0]        next_state_id;
    logic signed [31:0] next_value;
    logic               episode_done;

    modport source
    (
        output valid, cur_state_id, act, reward, next_state_id, next_value, episode_done,
        input  ready
    );

    modport sink
    (
        input  valid, cur_state_id, act, reward, next_state_id, next_value, episode_done,
        output ready
    );
endinterface

// ----- design/nsdr_out_if.sv -----
// ----------------------------------------------------------------------------
// nsdr_out_if
// Result channel: valid/ready handshake with one n-step return as payload.
// ----------------------------------------------------------------------------
interface nsdr_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        out_state_id;
    logic [7:0]         out_action;
    logic signed [31:0] discounted_return;
    logic [15:0]        out_next_state_id;
    logic               out_done;
    logic               last;

    modport source
    (
        output valid, out_state_id, out_action, discounted_return, out_next_state_id,
               out_done, last,
        input  ready
    );

    modport sink
    (
        input  valid, out_state_id, out_action, discounted_return, out_next_state_id,
               out_done, last,
        output ready
    );
endinterface

// ----- design/n_step_discounted_return_top.sv -----
// ----------------------------------------------------------------------------
// n_step_discounted_return_top
// Flow: a transition that causes no result is retired after the window check;
//   each result sums n rewards and, unless the episode ends, a bootstrap term
//   in the single multiply-accumulate pipeline that reads the window buffer
//   one entry per cycle.
// Throughput: one transition at a time in the engine; the two-slot queue
//   keeps intake open while a result waits at the output register.
// Reset: clears window count, head and tail pointers and handshake state, sets
//   gamma and window length to their defaults; window storage is not cleared.
// ----------------------------------------------------------------------------
module n_step_discounted_return_top import nsdr_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    nsdr_in_if.sink                in_ch,
    nsdr_out_if.source             out_ch
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic             push_valid;
    logic             push_ready;
    item_t            push_item;
    logic             pop_valid;
    logic             pop_ready;
    item_t            pop_item;
    logic [15:0]      gamma_clamped;
    logic [CNT_W-1:0] len_clamped;

    nsdr_front #(.MAX_WINDOW(MAX_WINDOW)) u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_ch         (in_ch),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item),
        .gamma_clamped (gamma_clamped),
        .len_clamped   (len_clamped)
    );

    nsdr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    nsdr_back #(.MAX_WINDOW(MAX_WINDOW)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .gamma_clamped (gamma_clamped),
        .len_clamped   (len_clamped),
        .out_ch        (out_ch)
    );

endmodule

// ----- design/nsdr_front.sv -----
// ----------------------------------------------------------------------------
// nsdr_front
// Configuration registers, transition intake and clamping of gamma and
// window length into the ranges the back end works with.
// ----------------------------------------------------------------------------
module nsdr_front import nsdr_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [CFG_INDEX_W-1:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_data,
    nsdr_in_if.sink                            in_ch,
    output logic                               push_valid,
    input  logic                               push_ready,
    output item_t                              push_item,
    output logic [15:0]                        gamma_clamped,
    output logic [$clog2(MAX_WINDOW+1)-1:0]    len_clamped
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LW    = (CNT_W > 4) ? CNT_W : 4;

    logic [15:0]   gamma_reg;
    logic [3:0]    wlen_reg;
    logic [LW-1:0] wlen_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
            wlen_reg  <= WINDOW_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAMMA:         gamma_reg <= cfg_data;
                CFG_WINDOW_LENGTH: wlen_reg  <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // gamma above one acts as one
    assign gamma_clamped = (gamma_reg > GAMMA_ONE) ? GAMMA_ONE : gamma_reg;

    assign wlen_ext = LW'(wlen_reg);

    always_comb
    begin
        if (wlen_reg == 4'd0)
            len_clamped = CNT_W'(1);
        else if (wlen_ext > LW'(MAX_WINDOW))
            len_clamped = CNT_W'(MAX_WINDOW);
        else
            len_clamped = CNT_W'(wlen_ext);
    end

    assign push_valid  = in_ch.valid;
    assign in_ch.ready = push_ready;

    assign push_item = '{
        cur_state_id:  in_ch.cur_state_id,
        act:           in_ch.act,
        reward:        in_ch.reward,
        next_state_id: in_ch.next_state_id,
        next_value:    in_ch.next_value,
        episode_done:  in_ch.episode_done
    };

endmodule

// ----- design/nsdr_queue.sv -----
// ----------------------------------------------------------------------------
// nsdr_queue
// Two-slot queue between intake and the return engine.
// ----------------------------------------------------------------------------
module nsdr_queue import nsdr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t slot0_reg;
    item_t slot1_reg;
    logic  v0_reg;
    logic  v1_reg;
    logic  push;
    logic  pop;

    assign push_ready = !v1_reg;
    assign pop_valid  = v0_reg;
    assign pop_item   = slot0_reg;
    assign push       = push_valid && push_ready;
    assign pop        = v0_reg && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (v1_reg)
            begin
                // advance the second slot; no push can happen while full
                slot0_reg <= slot1_reg;
                v1_reg    <= 1'b0;
            end
            else
            begin
                v0_reg <= push;
                if (push)
                    slot0_reg <= push_item;
            end
        end
        else if (push)
        begin
            if (!v0_reg)
            begin
                slot0_reg <= push_item;
                v0_reg    <= 1'b1;
            end
            else
            begin
                slot1_reg <= push_item;
                v1_reg    <= 1'b1;
            end
        end
    end

endmodule

// ----- design/nsdr_back.sv -----
// ----------------------------------------------------------------------------
// nsdr_back
// Return engine: keeps the transition window in a circular buffer and runs
// one multiply-accumulate pipeline over it for each emitted return.
// ----------------------------------------------------------------------------
module nsdr_back import nsdr_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  item_t                           pop_item,
    input  logic [15:0]                     gamma_clamped,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] len_clamped,
    nsdr_out_if.source                      out_ch
);

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PROD_W = 49;
    localparam int ACC_W  = PROD_W + $clog2(MAX_WINDOW + 2);

    typedef enum logic [2:0] {IDLE, CHECK, RUN, DRAIN, FIN} state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(MAX_WINDOW - 1))
            ptr_inc = '0;
        else
            ptr_inc = p + 1'b1;
    endfunction

    // window storage
    logic signed [31:0] reward_mem [MAX_WINDOW];
    logic [15:0]        tag_mem    [MAX_WINDOW];
    logic [7:0]         act_mem    [MAX_WINDOW];

    state_t             state_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   t_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   len_reg;
    logic [15:0]        g_reg;
    logic [15:0]        pw_reg;
    logic               done_reg;
    logic signed [31:0] nv_reg;
    logic [15:0]        ntag_reg;

    logic               a_valid_reg;
    logic               a_nv_reg;
    logic [15:0]        a_pw_reg;
    logic signed [31:0] rd_data_reg;
    logic               b_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [31:0] res_reg;
    logic [15:0]        oldest_tag_reg;
    logic [7:0]         oldest_act_reg;

    logic               out_valid_reg;
    logic [15:0]        out_state_id_reg;
    logic [7:0]         out_action_reg;
    logic signed [31:0] out_return_reg;
    logic [15:0]        out_next_id_reg;
    logic               out_done_reg;
    logic               out_last_reg;

    logic                     pop_fire;
    logic                     out_free;
    logic                     more;
    logic                     last_calc;
    logic [CNT_W-1:0]         cnt_after;
    logic [31:0]              pw_prod;
    logic [15:0]              pw_next;
    logic signed [31:0]       op;
    logic signed [PROD_W-1:0] op_ext;
    logic signed [PROD_W-1:0] pw_ext;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shr;
    logic [ACC_W-32:0]        hi;
    logic signed [31:0]       sat;

    assign pop_ready = (state_reg == IDLE);
    assign pop_fire  = pop_valid && pop_ready;
    assign out_free  = !out_valid_reg || out_ch.ready;

    assign more      = (count_reg >= len_reg) || (done_reg && (count_reg != '0));
    assign cnt_after = count_reg - 1'b1;
    assign last_calc = !((cnt_after >= len_reg) || (done_reg && (cnt_after != '0)));

    // next gamma power, rounded Q1.15
    assign pw_prod = {16'd0, pw_reg} * {16'd0, g_reg} + 32'(ROUND_HALF);
    assign pw_next = pw_prod[30:15];

    assign op        = a_nv_reg ? nv_reg : rd_data_reg;
    assign op_ext    = {{(PROD_W-32){op[31]}}, op};
    assign pw_ext    = {{(PROD_W-16){1'b0}}, a_pw_reg};
    assign prod_full = op_ext * pw_ext;

    // round to Q16.16 and saturate
    assign rnd = acc_reg + ACC_W'(ROUND_HALF);
    assign shr = rnd >>> FRAC_SHIFT;
    assign hi  = shr[ACC_W-1:31];

    always_comb
    begin
        if ((&hi) || !(|hi))
            sat = shr[31:0];
        else if (shr[ACC_W-1])
            sat = 32'sh8000_0000;
        else
            sat = 32'sh7FFF_FFFF;
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            reward_mem[tail_reg] <= pop_item.reward;
            tag_mem[tail_reg]    <= pop_item.cur_state_id;
            act_mem[tail_reg]    <= pop_item.act;
        end
        rd_data_reg    <= reward_mem[rd_ptr_reg];
        oldest_tag_reg <= tag_mem[head_reg];
        oldest_act_reg <= act_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= a_valid_reg;
            prod_reg    <= prod_full;
            if (b_valid_reg)
                acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                IDLE:
                begin
                    if (pop_fire)
                    begin
                        nv_reg    <= pop_item.next_value;
                        done_reg  <= pop_item.episode_done;
                        ntag_reg  <= pop_item.next_state_id;
                        g_reg     <= gamma_clamped;
                        len_reg   <= len_clamped;
                        tail_reg  <= ptr_inc(tail_reg);
                        count_reg <= count_reg + 1'b1;
                        state_reg <= CHECK;
                    end
                end
                CHECK:
                begin
                    if (more)
                    begin
                        n_reg      <= (count_reg < len_reg) ? count_reg : len_reg;
                        t_reg      <= '0;
                        pw_reg     <= GAMMA_ONE;
                        rd_ptr_reg <= head_reg;
                        acc_reg    <= '0;
                        state_reg  <= RUN;
                    end
                    else
                        state_reg <= IDLE;
                end
                RUN:
                begin
                    if (t_reg != n_reg)
                    begin
                        a_valid_reg <= 1'b1;
                        a_nv_reg    <= 1'b0;
                        a_pw_reg    <= pw_reg;
                        rd_ptr_reg  <= ptr_inc(rd_ptr_reg);
                        t_reg       <= t_reg + 1'b1;
                        pw_reg      <= pw_next;
                    end
                    else
                    begin
                        // bootstrap term only when the episode goes on
                        if (!done_reg)
                        begin
                            a_valid_reg <= 1'b1;
                            a_nv_reg    <= 1'b1;
                            a_pw_reg    <= pw_reg;
                        end
                        state_reg <= DRAIN;
                    end
                end
                DRAIN:
                begin
                    if (!a_valid_reg && !b_valid_reg)
                    begin
                        res_reg   <= sat;
                        state_reg <= FIN;
                    end
                end
                FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_state_id_reg <= oldest_tag_reg;
                        out_action_reg   <= oldest_act_reg;
                        out_return_reg   <= res_reg;
                        out_next_id_reg  <= ntag_reg;
                        out_done_reg     <= done_reg;
                        out_last_reg     <= last_calc;
                        // drop the oldest entry
                        head_reg         <= ptr_inc(head_reg);
                        count_reg        <= cnt_after;
                        state_reg        <= CHECK;
                    end
                end
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.out_state_id      = out_state_id_reg;
    assign out_ch.out_action        = out_action_reg;
    assign out_ch.discounted_return = out_return_reg;
    assign out_ch.out_next_state_id = out_next_id_reg;
    assign out_ch.out_done          = out_done_reg;
    assign out_ch.last              = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_WINDOW))
        else $error("window count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FIN) |-> (!a_valid_reg && !b_valid_reg))
        else $error("result taken before the accumulate pipeline drained");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == FIN))
        else $error("result loaded outside the finish step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RUN) |-> (t_reg <= n_reg && n_reg <= count_reg))
        else $error("term counter ran past the window");

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the n-step discounted return builder. Transitions
// are driven over the input channel and the results are checked against a
// predictor that keeps its own copy of the reward window and of the gamma
// and window length registers. A directed part covers the field and register
// extremes. Random phases follow, each with new register values, and run
// mostly whole episodes with some stray done flags mixed in. Random idle
// cycles are inserted on both channels.
// ----------------------------------------------------------------------------
module tb_top import nsdr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 67;
    localparam int DRAIN_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT   = 5000;

    typedef struct packed {
        logic [15:0]        out_state_id;
        logic [7:0]         out_action;
        logic signed [31:0] discounted_return;
        logic [15:0]        out_next_state_id;
        logic               out_done;
        logic               last;
    } ret_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    nsdr_in_if  in_ch ();
    nsdr_out_if out_ch ();

    n_step_discounted_return_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic [15:0]        gamma_q15;
    logic [3:0]         window_len;
    logic signed [31:0] win_reward [MAX_WINDOW_DEF];
    logic [15:0]        win_tag    [MAX_WINDOW_DEF];
    logic [7:0]         win_act    [MAX_WINDOW_DEF];
    int unsigned        win_count;
    logic [15:0]        newest_tag;

    item_t transition_q [$];
    ret_t  return_q [$];

    int    error_count;
    int    items_sent;
    int    items_accepted;
    int    returns_checked;
    int    settings_used;
    int    quiet_cycles;

    item_t next_tr;
    int    send_gap;
    int    send_calm;
    int    recv_stall;
    int    recv_calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void retire_oldest();
        int i;
        for (i = 0; i < MAX_WINDOW_DEF - 1; i++)
        begin
            win_reward[i] = win_reward[i+1];
            win_tag[i]    = win_tag[i+1];
            win_act[i]    = win_act[i+1];
        end
        win_count--;
    endfunction

    function automatic void predict_returns(input item_t tr);
        logic [15:0] g;
        int unsigned len;
        int unsigned n;
        int unsigned p;
        int unsigned t;
        longint      acc;
        longint      r;
        int          produced;
        ret_t        res;
        g = (gamma_q15 > GAMMA_ONE) ? GAMMA_ONE : gamma_q15;
        len = (window_len == 0) ? 1 :
              (window_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : window_len;
        produced = 0;

        if (win_count >= MAX_WINDOW_DEF)
            retire_oldest();
        win_reward[win_count] = tr.reward;
        win_tag[win_count]    = tr.cur_state_id;
        win_act[win_count]    = tr.act;
        win_count++;
        newest_tag = tr.next_state_id;

        while (win_count >= len || (tr.episode_done && win_count > 0))
        begin
            n = (win_count < len) ? win_count : len;
            p = 32768;
            acc = 0;
            for (t = 0; t < n; t++)
            begin
                acc += longint'(win_reward[t]) * longint'(p);
                p = (p * g + ROUND_HALF) >> FRAC_SHIFT;
            end
            if (!tr.episode_done)
                acc += longint'($signed(tr.next_value)) * longint'(p);
            // arithmetic shift gives the floor
            r = (acc + ROUND_HALF) >>> FRAC_SHIFT;
            if (r > longint'(32'sh7FFF_FFFF))
                r = longint'(32'sh7FFF_FFFF);
            if (r < -longint'(64'sh8000_0000))
                r = -longint'(64'sh8000_0000);

            res.out_state_id      = win_tag[0];
            res.out_action        = win_act[0];
            res.discounted_return = r[31:0];
            res.out_next_state_id = newest_tag;
            res.out_done          = tr.episode_done;
            res.last              = 1'b0;
            return_q.insert(return_q.size(), res);
            produced++;
            retire_oldest();
        end
        if (produced > 0)
            return_q[return_q.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int draw_gap(inout int calm_left);
        int pick;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (pick < 60)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] draw_q16();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            5, 6, 7:       return $urandom;
            8:             return 32'h7FFF_FFFF;
            default:       return 32'h8000_0000;
        endcase
    endfunction

    function automatic void push_transition(logic [15:0] tag, logic [7:0] act,
                                            logic [31:0] reward, logic [15:0] next_tag,
                                            logic [31:0] next_value, logic done);
        item_t tr;
        tr.cur_state_id  = tag;
        tr.act           = act;
        tr.reward        = reward;
        tr.next_state_id = next_tag;
        tr.next_value    = next_value;
        tr.episode_done  = done;
        transition_q.insert(transition_q.size(), tr);
        items_sent++;
    endfunction

    function automatic void push_random(logic done);
        push_transition(16'($urandom), 8'($urandom), draw_q16(), 16'($urandom),
                        draw_q16(), done);
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_GAMMA)
            gamma_q15 = value;
        else
            window_len = value[3:0];
    endtask

    // wait until every transaction has gone through, then let the engine retire
    task automatic wait_idle();
        while (items_accepted != items_sent || return_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic new_setting(input logic [15:0] g, input logic [3:0] len);
        write_reg(CFG_GAMMA, g);
        write_reg(CFG_WINDOW_LENGTH, {12'h000, len});
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          phase;
        int          left;
        int          run;
        int          k;
        logic [15:0] g;
        logic [3:0]  len;
        int          directed_items;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_GAMMA;
        cfg_data           = '0;
        in_ch.valid         = 1'b0;
        in_ch.cur_state_id  = '0;
        in_ch.act           = '0;
        in_ch.reward        = '0;
        in_ch.next_state_id = '0;
        in_ch.next_value    = '0;
        in_ch.episode_done  = 1'b0;
        out_ch.ready        = 1'b0;
        gamma_q15       = GAMMA_RESET;
        window_len      = WINDOW_LENGTH_RESET;
        win_count       = 0;
        newest_tag      = '0;
        error_count     = 0;
        items_sent      = 0;
        items_accepted  = 0;
        returns_checked = 0;
        settings_used   = 1;
        quiet_cycles    = 0;
        send_gap        = 0;
        send_calm       = 0;
        recv_stall      = 0;
        recv_calm       = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: fill the window with maximum rewards, then end the episode
        for (k = 0; k < 9; k++)
            push_transition(k[0] ? 16'hFFFF : 16'h0000, k[0] ? 8'hFF : 8'h00,
                            32'h7FFF_FFFF, k[0] ? 16'h0000 : 16'hFFFF,
                            32'h7FFF_FFFF, 1'b0);
        push_transition(16'h1234, 8'h5A, 32'h8000_0000, 16'hBEEF, 32'h8000_0000, 1'b1);
        wait_idle();

        // gamma above one, window length zero
        new_setting(16'hFFFF, 4'd0);
        push_transition(16'hFFFF, 8'hFF, 32'h8000_0000, 16'hFFFF, 32'h8000_0000, 1'b0);
        push_transition(16'h0000, 8'h00, 32'h0000_0000, 16'h0000, 32'h7FFF_FFFF, 1'b0);
        push_transition(16'hA5A5, 8'h3C, 32'h7FFF_FFFF, 16'h5A5A, 32'h0000_0000, 1'b1);
        wait_idle();

        // gamma zero, oversized window; then shrink the window below the fill level
        new_setting(16'h0000, 4'd15);
        for (k = 0; k < 5; k++)
            push_random(1'b0);
        wait_idle();
        write_reg(CFG_WINDOW_LENGTH, 16'd2);
        push_random(1'b0);
        wait_idle();
        new_setting(GAMMA_ONE, 4'd8);
        push_random(1'b1);
        wait_idle();
        directed_items = items_sent;

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin g = GAMMA_ONE; len = 4'd1; end
                1: begin g = 16'h0000;  len = 4'd8; end
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       g = GAMMA_ONE;
                        1:       g = 16'h0000;
                        2:       g = 16'($urandom_range(32769, 65535));
                        3:       g = 16'($urandom_range(29000, 32768));
                        default: g = 16'($urandom_range(0, 65535));
                    endcase
                    if ($urandom_range(0, 9) < 7)
                        len = 4'($urandom_range(1, 8));
                    else
                        len = 4'($urandom_range(0, 15));
                end
            endcase
            new_setting(g, len);

            left = ITEMS_PER_PHASE;
            while (left > 0)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    // whole episode, done only on its final step
                    run = $urandom_range(1, 20);
                    for (k = 0; k < run && left > 0; k++)
                    begin
                        push_random(k == run - 1);
                        left--;
                    end
                end
                else
                begin
                    run = $urandom_range(1, 5);
                    for (k = 0; k < run && left > 0; k++)
                    begin
                        push_random(1'($urandom_range(0, 1)));
                        left--;
                    end
                end
            end
            wait_idle();
        end

        $display("Sent %0d transitions (%0d directed) and checked %0d returns",
                 items_accepted, directed_items, returns_checked);
        $display("across %0d register settings, gamma from zero to above one, window 0 to 15",
                 settings_used);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: hold each transaction until accepted, then maybe idle
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_ch.ready))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (transition_q.size() > 0)
            begin
                next_tr = transition_q[0];
                transition_q.delete(0);
                in_ch.valid         <= 1'b1;
                in_ch.cur_state_id  <= next_tr.cur_state_id;
                in_ch.act           <= next_tr.act;
                in_ch.reward        <= next_tr.reward;
                in_ch.next_state_id <= next_tr.next_state_id;
                in_ch.next_value    <= next_tr.next_value;
                in_ch.episode_done  <= next_tr.episode_done;
                send_gap = draw_gap(send_calm);
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall = draw_gap(recv_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        item_t seen;
        ret_t  want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            seen.cur_state_id  = in_ch.cur_state_id;
            seen.act           = in_ch.act;
            seen.reward        = in_ch.reward;
            seen.next_state_id = in_ch.next_state_id;
            seen.next_value    = in_ch.next_value;
            seen.episode_done  = in_ch.episode_done;
            predict_returns(seen);
            items_accepted++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (return_q.size() == 0)
            begin
                $error("unexpected return transaction: state tag %h, return %h",
                       out_ch.out_state_id, out_ch.discounted_return);
                error_count++;
            end
            else
            begin
                want = return_q[0];
                return_q.delete(0);
                compare_field("out_state_id", 32'(want.out_state_id),
                              32'(out_ch.out_state_id));
                compare_field("out_action", 32'(want.out_action), 32'(out_ch.out_action));
                compare_field("discounted_return", want.discounted_return,
                              out_ch.discounted_return);
                compare_field("out_next_state_id", 32'(want.out_next_state_id),
                              32'(out_ch.out_next_state_id));
                compare_field("out_done", 32'(want.out_done), 32'(out_ch.out_done));
                compare_field("last", 32'(want.last), 32'(out_ch.last));
                returns_checked++;
            end
        end
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
